// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the totient range sum block.
// ----------------------------------------------------------------------------
// Both macros expect a signal named clk, and TRS_ASSERT also one named rst, in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside of reset.
`define TRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("Assertion failed.");
// Checked at every clock edge, reset included.
`define TRS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("Assertion failed.");
`else
`define TRS_ASSERT(label, prop)
`define TRS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== rtl/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// Totient range sum package
// Shared constants, divider operand codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  // Result width and saturation limit of the running sum.
  localparam int unsigned SUM_W = 31;
  localparam logic [SUM_W-1:0] SUM_MAX = 31'h7FFF_FFFF;

  // Operand pairs the shared divider can be launched on.
  typedef enum logic [1:0] {
    DIV_M_BY_P = 2'd0,  // remaining cofactor by trial divisor
    DIV_R_BY_P = 2'd1,  // partial totient by found prime
    DIV_R_BY_M = 2'd2   // partial totient by leftover large prime
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;  // latch bounds, clear sum
    logic     init_n;     // m = n, res = n, p = 2, flag cleared
    logic     zero_res;   // n below two contributes nothing
    logic     div_start;  // launch the divider
    div_sel_t div_sel;    // divider operands
    logic     take_m;     // m = quotient, mark prime found
    logic     sub_res;    // res = res - quotient
    logic     clr_flag;   // prime handled
    logic     step_p;     // next trial divisor
    logic     acc;        // add res into the saturating sum
    logic     step_n;     // next n of the range
    logic     out_load;   // move sum into the output register
  } trs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;  // lower bound above upper bound at the inputs
    logic n_lt2;        // current n is zero or one
    logic n_last;       // current n equals the upper bound
    logic psq_gt_m;     // trial divisor squared exceeds cofactor
    logic m_gt1;        // a large prime factor is left over
    logic div_done;     // divider result is ready this cycle
    logic rem_zero;     // divider remainder is zero
    logic flag;         // current trial divisor divides n
    logic out_free;     // output register can take a result
  } trs_status_t;

endpackage

`default_nettype wire

// ===== rtl/trs_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module trs_div #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [NUM_BITS-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient,
  output logic [NUM_BITS-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0] rem_r;
  logic [NUM_BITS-1:0] quo_r;
  logic [NUM_BITS-1:0] div_r;
  logic [CNT_W-1:0]    cnt;
  logic [NUM_BITS:0]   shifted;
  logic [NUM_BITS:0]   diff;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem_r, quo_r[NUM_BITS-1]};
    diff    = shifted - {1'b0, div_r};
  end

  // Control: busy while the quotient bits are formed, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy) begin
      if (!diff[NUM_BITS]) begin
        rem_r <= diff[NUM_BITS-1:0];
        quo_r <= {quo_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_r <= shifted[NUM_BITS-1:0];
        quo_r <= {quo_r[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;

  `TRS_ASSERT(a_no_restart_while_busy, start |-> !busy)
  `TRS_ASSERT(a_start_runs, start |=> busy && !done)
  `TRS_ASSERT_ALWAYS(a_reset_idles, rst |=> !busy && !done)

endmodule

`default_nettype wire

// ===== rtl/trs_datapath.sv =====
// ----------------------------------------------------------------------------
// Totient range sum datapath
// Range counter, trial division registers, shared divider and the sum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module trs_datapath #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  trs_pkg::trs_cmd_t        cmd,
  output trs_pkg::trs_status_t     status,
  input  logic [NUM_BITS-1:0]      lower_bound,
  input  logic [NUM_BITS-1:0]      upper_bound,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [trs_pkg::SUM_W-1:0] totient_sum
);
  import trs_pkg::*;

  localparam int unsigned PSQ_W = 2 * NUM_BITS + 1;
  localparam int unsigned ACC_W = ((NUM_BITS > SUM_W) ? NUM_BITS : SUM_W) + 1;

  logic [NUM_BITS-1:0] n;
  logic [NUM_BITS-1:0] hi;
  logic [NUM_BITS-1:0] m;
  logic [NUM_BITS-1:0] res;
  logic [NUM_BITS-1:0] p;
  logic [PSQ_W-1:0]    psq;
  logic                flag;
  logic [SUM_W-1:0]    sum;
  logic [ACC_W-1:0]    sum_add;

  logic [NUM_BITS-1:0] div_a;
  logic [NUM_BITS-1:0] div_b;
  logic                div_busy;
  logic                div_done;
  logic [NUM_BITS-1:0] div_q;
  logic [NUM_BITS-1:0] div_r;

  // Divider operand selection.
  always_comb begin
    unique case (cmd.div_sel)
      DIV_M_BY_P: begin
        div_a = m;
        div_b = p;
      end
      DIV_R_BY_P: begin
        div_a = res;
        div_b = p;
      end
      DIV_R_BY_M: begin
        div_a = res;
        div_b = m;
      end
      default: begin
        div_a = m;
        div_b = p;
      end
    endcase
  end

  trs_div #(
    .NUM_BITS(NUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // Saturating sum update.
  assign sum_add = ACC_W'(sum) + ACC_W'(res);

  // Range counter, factoring registers and running sum.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      n   <= lower_bound;
      hi  <= upper_bound;
      sum <= '0;
    end
    if (cmd.init_n) begin
      m   <= n;
      res <= n;
      p   <= NUM_BITS'(2);
      psq <= PSQ_W'(4);
    end
    if (cmd.zero_res) begin
      res <= '0;
    end
    if (cmd.take_m) begin
      m <= div_q;
    end
    if (cmd.sub_res) begin
      res <= res - div_q;
    end
    if (cmd.step_p) begin
      p   <= p + 1'b1;
      psq <= psq + PSQ_W'({p, 1'b1});
    end
    if (cmd.acc) begin
      sum <= (sum_add > ACC_W'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
    end
    if (cmd.step_n) begin
      n <= n + 1'b1;
    end
  end

  // Prime-found flag for the current trial divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (cmd.init_n || cmd.clr_flag) begin
      flag <= 1'b0;
    end else if (cmd.take_m) begin
      flag <= 1'b1;
    end
  end

  // Output register: holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      totient_sum <= sum;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.range_empty = lower_bound > upper_bound;
    status.n_lt2       = n < NUM_BITS'(2);
    status.n_last      = n == hi;
    status.psq_gt_m    = psq > PSQ_W'(m);
    status.m_gt1       = m > NUM_BITS'(1);
    status.div_done    = div_done;
    status.rem_zero    = div_r == '0;
    status.flag        = flag;
    status.out_free    = !out_valid || !out_stall;
  end

  `TRS_ASSERT(a_cofactor_exact, cmd.take_m |-> div_done && div_r == '0)
  `TRS_ASSERT(a_res_no_underflow, cmd.sub_res |-> div_done && div_q <= res)
  `TRS_ASSERT(a_out_no_overwrite, cmd.out_load |-> !out_valid || !out_stall)
  `TRS_ASSERT(a_div_idle_at_start, cmd.div_start |-> !div_busy)

endmodule

`default_nettype wire

// ===== rtl/trs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Totient range sum controller
// Sequences range stepping, trial division and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  trs_pkg::trs_status_t status,
  output trs_pkg::trs_cmd_t    cmd
);
  import trs_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_NEXT    = 9'b000000010,
    ST_TEST    = 9'b000000100,
    ST_WAIT_M  = 9'b000001000,
    ST_REDIV_M = 9'b000010000,
    ST_WAIT_R  = 9'b000100000,
    ST_WAIT_F  = 9'b001000000,
    ST_ACC     = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != ST_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_M_BY_P;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = status.range_empty ? ST_DONE : ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status.n_lt2) begin
          cmd.zero_res = 1'b1;
          state_next = ST_ACC;
        end else begin
          cmd.init_n = 1'b1;
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!status.psq_gt_m) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_M_BY_P;
          state_next = ST_WAIT_M;
        end else if (status.m_gt1) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_R_BY_M;
          state_next = ST_WAIT_F;
        end else begin
          state_next = ST_ACC;
        end
      end
      ST_WAIT_M: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.take_m = 1'b1;
            state_next = ST_REDIV_M;
          end else if (status.flag) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_R_BY_P;
            state_next = ST_WAIT_R;
          end else begin
            cmd.step_p = 1'b1;
            state_next = ST_TEST;
          end
        end
      end
      ST_REDIV_M: begin
        // Divide the reduced cofactor by the same prime again.
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_M_BY_P;
        state_next = ST_WAIT_M;
      end
      ST_WAIT_R: begin
        if (status.div_done) begin
          cmd.sub_res  = 1'b1;
          cmd.clr_flag = 1'b1;
          cmd.step_p   = 1'b1;
          state_next = ST_TEST;
        end
      end
      ST_WAIT_F: begin
        if (status.div_done) begin
          cmd.sub_res = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (status.n_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.step_n = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/totient_range_sum.sv =====
// ----------------------------------------------------------------------------
// Totient range sum
// Sum of Euler totients over an inclusive range, by trial-division factoring.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  lower_bound, upper_bound
// output   out        out_valid / out_stall totient_sum
//
// One range is processed at a time. Each n of two or more takes one division
// per trial divisor tried, another each time a prime divides it, and one per
// distinct prime to scale the partial totient; the shared iterative divider
// does them all, one quotient bit per cycle. Every n also passes through range
// stepping and accumulation. An empty range skips straight to the result.
// No clearing pass follows reset. A finished result waits in the output register,
// and the next transaction is taken while it waits.
`default_nettype none

module totient_range_sum #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [NUM_BITS-1:0]       lower_bound,
  input  logic [NUM_BITS-1:0]       upper_bound,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [trs_pkg::SUM_W-1:0] totient_sum
);
  import trs_pkg::*;

  trs_cmd_t    cmd;
  trs_status_t status;

  trs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  trs_datapath #(
    .NUM_BITS(NUM_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .lower_bound(lower_bound),
    .upper_bound(upper_bound),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .totient_sum(totient_sum)
  );

endmodule

`default_nettype wire
